FILE: hw/rtl/sorted_two_level_key_table_macros.svh
// Assertion macros shared by the key table RTL.
`ifndef SORTED_TWO_LEVEL_KEY_TABLE_MACROS_SVH
`define SORTED_TWO_LEVEL_KEY_TABLE_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define STKT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define STKT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hw/rtl/stkt_pkg.sv
// Shared constants for the sorted two-level key table.
`default_nettype none
package stkt_pkg;
   localparam int MAX_ACCOUNTS = 64;
   localparam int MAX_ASSETS   = 16;
   localparam int KEY_BITS     = 32;

   localparam int FIELD_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 6;
   localparam int CNTO_W   = 5;
   localparam int REQ_W    = 3 * FIELD_W;
   localparam int RSP_W    = STATUS_W + POS_W + 2 + FIELD_W + CNTO_W;

   localparam logic [FUNC_W-1:0] FN_CREATE = 2'd0;
   localparam logic [FUNC_W-1:0] FN_GET    = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
   localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
endpackage
`default_nettype wire

FILE: hw/rtl/stkt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module stkt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/sorted_two_level_key_table.sv
// Sorted two-level key table: accounts in key order, each with a sorted asset key list.
//
// One transaction at a time. The account RAM holds key, flag word, asset count and an asset
// row slot for each account in ascending key order; the asset RAM holds one row of asset keys
// per slot. A slot is given out in creation order and never moves, so inserting an account
// shifts only the account RAM words. The RAM ports move one word per cycle, so a lookup walks
// the account entries one at a time, an asset search walks the assets one at a time, and an
// insertion shifts each entry with a read and then a write; the result then passes through the
// output register. req_tready returns in the same cycle as rsp_tvalid.
// A new transaction is taken while the previous result still waits on the rsp side.
// No clearing pass after reset: only entries below the stored counts are ever used.
`default_nettype none
`include "sorted_two_level_key_table_macros.svh"
module sorted_two_level_key_table #(
   parameter int MAX_ACCOUNTS = stkt_pkg::MAX_ACCOUNTS,
   parameter int MAX_ASSETS   = stkt_pkg::MAX_ASSETS,
   parameter int KEY_BITS     = stkt_pkg::KEY_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // account_key[31:0], asset_key[63:32], new_flags[95:64]
   input  wire logic [stkt_pkg::REQ_W-1:0]  req_tdata,
   // func[1:0]
   input  wire logic [stkt_pkg::FUNC_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // status[2:0], position[8:3], created[9], asset_present[10], flags_out[42:11],
   // asset_total[47:43]
   output logic      [stkt_pkg::RSP_W-1:0]  rsp_tdata
);
   localparam int FW     = stkt_pkg::FIELD_W;
   localparam int POS_W  = stkt_pkg::POS_W;
   localparam int CNTO_W = stkt_pkg::CNTO_W;
   localparam int SW     = stkt_pkg::STATUS_W;
   localparam int ACC_W  = (MAX_ACCOUNTS > 1) ? $clog2(MAX_ACCOUNTS) : 1;
   localparam int CNT_W  = $clog2(MAX_ACCOUNTS + 1);
   localparam int AS_D   = MAX_ACCOUNTS * MAX_ASSETS;
   localparam int AST_AW = (AS_D > 1) ? $clog2(AS_D) : 1;
   localparam int AT_W   = $clog2(MAX_ASSETS + 1);
   localparam int ENT_W  = KEY_BITS + FW + AT_W + ACC_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ACC_SCAN = 4'd1;
   localparam logic [3:0] S_ACC_RD   = 4'd2;
   localparam logic [3:0] S_ACC_WR   = 4'd3;
   localparam logic [3:0] S_ACC_INS  = 4'd4;
   localparam logic [3:0] S_AST_SCAN = 4'd5;
   localparam logic [3:0] S_AST_RD   = 4'd6;
   localparam logic [3:0] S_AST_WR   = 4'd7;
   localparam logic [3:0] S_AST_INS  = 4'd8;
   localparam logic [3:0] S_RESULT   = 4'd9;

   // Row base plus index inside the row.
   function automatic logic [AST_AW-1:0] ast_addr(input logic [ACC_W-1:0] slot,
                                                  input logic [AT_W-1:0] idx);
      ast_addr = AST_AW'(int'(slot) * MAX_ASSETS + int'(idx));
   endfunction

   logic [3:0]                    state_ff, state_in;
   logic [stkt_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [KEY_BITS-1:0]           akey_ff, akey_in, skey_ff, skey_in;
   logic [FW-1:0]                 nflags_ff, nflags_in;
   logic [CNT_W-1:0]              total_ff, total_in, idx_ff, idx_in, jdx_ff, jdx_in;
   logic [AT_W-1:0]               aidx_ff, aidx_in, ajdx_ff, ajdx_in;
   logic [FW-1:0]                 ent_flags_ff, ent_flags_in;
   logic [AT_W-1:0]               ent_cnt_ff, ent_cnt_in;
   logic [ACC_W-1:0]              ent_slot_ff, ent_slot_in;
   logic [SW-1:0]                 res_status_ff, res_status_in;
   logic [POS_W-1:0]              res_pos_ff, res_pos_in;
   logic                          res_created_ff, res_created_in;
   logic                          res_present_ff, res_present_in;
   logic [FW-1:0]                 res_flags_ff, res_flags_in;
   logic [CNTO_W-1:0]             res_cnt_ff, res_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [stkt_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   // Account RAM ports
   logic              acc_we;
   logic [ACC_W-1:0]  acc_waddr, acc_raddr;
   logic [ENT_W-1:0]  acc_wdata, acc_rdata;
   // Asset RAM ports
   logic              ast_we;
   logic [AST_AW-1:0] ast_waddr, ast_raddr;
   logic [KEY_BITS-1:0] ast_wdata, ast_rdata;

   // Fields of the account word coming out of the RAM
   logic [KEY_BITS-1:0] rd_key;
   logic [FW-1:0]       rd_flags;
   logic [AT_W-1:0]     rd_cnt;
   logic [ACC_W-1:0]    rd_slot;
   assign rd_key   = acc_rdata[KEY_BITS-1:0];
   assign rd_flags = acc_rdata[KEY_BITS +: FW];
   assign rd_cnt   = acc_rdata[KEY_BITS+FW +: AT_W];
   assign rd_slot  = acc_rdata[KEY_BITS+FW+AT_W +: ACC_W];

   logic [CNT_W-1:0] idx_nx, jdx_m1;
   logic [AT_W-1:0]  aidx_nx, ajdx_m1;
   assign idx_nx  = idx_ff + CNT_W'(1);
   assign jdx_m1  = jdx_ff - CNT_W'(1);
   assign aidx_nx = aidx_ff + AT_W'(1);
   assign ajdx_m1 = ajdx_ff - AT_W'(1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic acc_end, acc_hit, ast_end, ast_hit;
      acc_end = (idx_ff == total_ff);
      acc_hit = !acc_end && (rd_key == akey_ff);
      ast_end = (aidx_ff == ent_cnt_ff);
      ast_hit = !ast_end && (ast_rdata == skey_ff);

      state_in       = state_ff;
      func_in        = func_ff;
      akey_in        = akey_ff;
      skey_in        = skey_ff;
      nflags_in      = nflags_ff;
      total_in       = total_ff;
      idx_in         = idx_ff;
      jdx_in         = jdx_ff;
      aidx_in        = aidx_ff;
      ajdx_in        = ajdx_ff;
      ent_flags_in   = ent_flags_ff;
      ent_cnt_in     = ent_cnt_ff;
      ent_slot_in    = ent_slot_ff;
      res_status_in  = res_status_ff;
      res_pos_in     = res_pos_ff;
      res_created_in = res_created_ff;
      res_present_in = res_present_ff;
      res_flags_in   = res_flags_ff;
      res_cnt_in     = res_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      acc_we    = 1'b0;
      acc_waddr = idx_ff[ACC_W-1:0];
      acc_wdata = acc_rdata;
      acc_raddr = '0;
      ast_we    = 1'b0;
      ast_waddr = ast_addr(ent_slot_ff, aidx_ff);
      ast_wdata = skey_ff;
      ast_raddr = ast_addr(ent_slot_ff, aidx_nx);

      unique case (state_ff)
         S_IDLE: begin
            // read of entry 0 goes out now, compared in the scan state
            if (req_tvalid) begin
               func_in        = req_tuser;
               akey_in        = KEY_BITS'(req_tdata[FW-1:0]);
               skey_in        = KEY_BITS'(req_tdata[2*FW-1:FW]);
               nflags_in      = req_tdata[3*FW-1:2*FW];
               idx_in         = '0;
               res_status_in  = stkt_pkg::ST_OK;
               res_pos_in     = '0;
               res_created_in = 1'b0;
               res_present_in = 1'b0;
               res_flags_in   = '0;
               res_cnt_in     = '0;
               priority if (req_tuser == stkt_pkg::FN_CREATE &&
                            KEY_BITS'(req_tdata[FW-1:0]) == '0) begin
                  res_status_in = stkt_pkg::ST_INVALID;
                  state_in      = S_RESULT;
               end else if (req_tuser == stkt_pkg::FN_CREATE &&
                            total_ff == CNT_W'(MAX_ACCOUNTS)) begin
                  res_status_in = stkt_pkg::ST_FULL;
                  state_in      = S_RESULT;
               end else if (KEY_BITS'(req_tdata[FW-1:0]) == '0) begin
                  res_status_in = stkt_pkg::ST_NOT_FOUND;
                  state_in      = S_RESULT;
               end else begin
                  state_in = S_ACC_SCAN;
               end
            end
         end
         S_ACC_SCAN: begin
            // data of entry idx is here; entry idx+1 is being fetched
            acc_raddr = idx_nx[ACC_W-1:0];
            if (!acc_end && rd_key < akey_ff) begin
               idx_in = idx_nx;
            end else begin
               ent_flags_in = rd_flags;
               ent_cnt_in   = rd_cnt;
               ent_slot_in  = rd_slot;
               aidx_in      = '0;
               if (func_ff == stkt_pkg::FN_CREATE) begin
                  if (acc_hit) begin
                     res_status_in = stkt_pkg::ST_DUPLICATE;
                     res_pos_in    = POS_W'(idx_ff);
                     res_flags_in  = rd_flags;
                     res_cnt_in    = CNTO_W'(rd_cnt);
                     state_in      = S_RESULT;
                  end else if (acc_end) begin
                     state_in = S_ACC_INS;
                  end else begin
                     jdx_in   = total_ff;
                     state_in = S_ACC_RD;
                  end
               end else if (!acc_hit) begin
                  res_status_in = stkt_pkg::ST_NOT_FOUND;
                  state_in      = S_RESULT;
               end else begin
                  res_flags_in = rd_flags;
                  res_cnt_in   = CNTO_W'(rd_cnt);
                  if (func_ff == stkt_pkg::FN_READ) begin
                     res_pos_in = POS_W'(idx_ff);
                     state_in   = S_RESULT;
                  end else if (skey_ff == '0) begin
                     if (func_ff == stkt_pkg::FN_GET) begin
                        res_status_in = stkt_pkg::ST_INVALID;
                     end
                     state_in = S_RESULT;
                  end else begin
                     ast_raddr = ast_addr(rd_slot, '0);
                     state_in  = S_AST_SCAN;
                  end
               end
            end
         end
         S_ACC_RD: begin
            acc_raddr = jdx_m1[ACC_W-1:0];
            state_in  = S_ACC_WR;
         end
         S_ACC_WR: begin
            // move entry j-1 up to j
            acc_we    = 1'b1;
            acc_waddr = jdx_ff[ACC_W-1:0];
            acc_wdata = acc_rdata;
            jdx_in    = jdx_m1;
            state_in  = (jdx_m1 == idx_ff) ? S_ACC_INS : S_ACC_RD;
         end
         S_ACC_INS: begin
            // new account owns the next unused asset row
            acc_we    = 1'b1;
            acc_waddr = idx_ff[ACC_W-1:0];
            acc_wdata = {total_ff[ACC_W-1:0], AT_W'(0), nflags_ff, akey_ff};
            total_in  = total_ff + CNT_W'(1);
            res_pos_in   = POS_W'(idx_ff);
            res_flags_in = nflags_ff;
            res_cnt_in   = '0;
            state_in     = S_RESULT;
         end
         S_AST_SCAN: begin
            if (!ast_end && ast_rdata < skey_ff) begin
               aidx_in = aidx_nx;
            end else if (func_ff == stkt_pkg::FN_QUERY) begin
               res_present_in = ast_hit;
               res_pos_in     = ast_hit ? POS_W'(aidx_ff) : '0;
               state_in       = S_RESULT;
            end else if (ast_hit) begin
               res_pos_in = POS_W'(aidx_ff);
               state_in   = S_RESULT;
            end else if (ent_cnt_ff == AT_W'(MAX_ASSETS)) begin
               res_status_in = stkt_pkg::ST_FULL;
               state_in      = S_RESULT;
            end else if (ast_end) begin
               state_in = S_AST_INS;
            end else begin
               ajdx_in  = ent_cnt_ff;
               state_in = S_AST_RD;
            end
         end
         S_AST_RD: begin
            ast_raddr = ast_addr(ent_slot_ff, ajdx_m1);
            state_in  = S_AST_WR;
         end
         S_AST_WR: begin
            ast_we    = 1'b1;
            ast_waddr = ast_addr(ent_slot_ff, ajdx_ff);
            ast_wdata = ast_rdata;
            ajdx_in   = ajdx_m1;
            state_in  = (ajdx_m1 == aidx_ff) ? S_AST_INS : S_AST_RD;
         end
         S_AST_INS: begin
            // store key and bump the account's asset count
            ast_we    = 1'b1;
            ast_waddr = ast_addr(ent_slot_ff, aidx_ff);
            ast_wdata = skey_ff;
            acc_we    = 1'b1;
            acc_waddr = idx_ff[ACC_W-1:0];
            acc_wdata = {ent_slot_ff, ent_cnt_ff + AT_W'(1), ent_flags_ff, akey_ff};
            res_created_in = 1'b1;
            res_pos_in     = POS_W'(aidx_ff);
            res_cnt_in     = CNTO_W'(ent_cnt_ff + AT_W'(1));
            state_in       = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_cnt_ff, res_flags_ff, res_present_ff, res_created_ff,
                               res_pos_ff, res_status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      akey_ff        <= akey_in;
      skey_ff        <= skey_in;
      nflags_ff      <= nflags_in;
      idx_ff         <= idx_in;
      jdx_ff         <= jdx_in;
      aidx_ff        <= aidx_in;
      ajdx_ff        <= ajdx_in;
      ent_flags_ff   <= ent_flags_in;
      ent_cnt_ff     <= ent_cnt_in;
      ent_slot_ff    <= ent_slot_in;
      res_status_ff  <= res_status_in;
      res_pos_ff     <= res_pos_in;
      res_created_ff <= res_created_in;
      res_present_ff <= res_present_in;
      res_flags_ff   <= res_flags_in;
      res_cnt_ff     <= res_cnt_in;
      rsp_data_ff    <= rsp_data_in;
   end

   stkt_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ACCOUNTS)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_addr (acc_raddr),
      .rd_data (acc_rdata)
   );

   stkt_ram #(.WIDTH(KEY_BITS), .DEPTH(AS_D)) u_ast_ram (
      .clock   (clock),
      .wr_en   (ast_we),
      .wr_addr (ast_waddr),
      .wr_data (ast_wdata),
      .rd_addr (ast_raddr),
      .rd_data (ast_rdata)
   );

   `STKT_ASSERT(a_total_bound, clock, reset, total_ff <= CNT_W'(MAX_ACCOUNTS), "account count over capacity")
   `STKT_ASSERT_IMP(a_total_step, clock, reset, !$past(reset) && total_ff != $past(total_ff), total_ff == $past(total_ff) + CNT_W'(1), "account count moved by other than one")
   `STKT_ASSERT_IMP(a_total_only_ins, clock, reset, !$past(reset) && $past(state_ff) != S_ACC_INS, $stable(total_ff), "account count changed outside insert")
   `STKT_ASSERT_IMP(a_ast_scan_bound, clock, reset, state_ff == S_AST_SCAN, aidx_ff <= ent_cnt_ff, "asset scan ran past asset count")
endmodule
`default_nettype wire
